@@ hdl/keyed_palette_pixel_merge_macros.svh @@
// Assertion macros for the keyed palette pixel merge checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef KEYED_PALETTE_PIXEL_MERGE_MACROS_SVH
`define KEYED_PALETTE_PIXEL_MERGE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KPPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kppm_pkg.sv @@
// Shared types and constants of the keyed palette pixel merge.
// Holds the key color table, register indexes, operation codes and
// the structs passed between modules. Depends on nothing.
`timescale 1ns / 1ps

package kppm_pkg;

    localparam int PIXEL_W  = 8;
    localparam int COLOR_W  = 24;
    localparam int DIM_W    = 13;
    localparam int MARGIN_W = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd480;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd2;

    localparam int KEY_TABLE_SIZE = 24;

    localparam logic [COLOR_W-1:0] KEY_COLORS [KEY_TABLE_SIZE] = '{
        24'h803020, 24'h803830, 24'h884038,
        24'h904030, 24'h984038, 24'h985850, 24'h986860, 24'h989898,
        24'hA06060, 24'hA07870, 24'hA08078, 24'hA08880, 24'hA09088, 24'hA0A0A0,
        24'hB09888, 24'hB0A8A0, 24'hB0B0B0, 24'hB8B8B8, 24'hB8C8C0,
        24'hC0C0C0, 24'hC0A098, 24'hC0B8B0, 24'hC8C8C8,
        24'hD0D0D0
    };

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MARGIN = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_PALETTE_WRITE = 1'b0,
        OP_PIXEL         = 1'b1
    } t_op;

    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [MARGIN_W-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic in_window;
        logic end_frame;
    } t_pos_info;

endpackage

@@ hdl/kppm_cfg.sv @@
// APB register file of the keyed palette pixel merge.
// Holds image width, image height and border margin; uses kppm_pkg.
`timescale 1ns / 1ps

module kppm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kppm_pkg::APB_AW-1:0]       paddr,
    input  logic [kppm_pkg::APB_DW-1:0]       pwdata,
    output logic [kppm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output kppm_pkg::t_cfg                    o_cfg
);

    kppm_pkg::t_cfg     r_cfg;
    kppm_pkg::t_cfg     n_cfg;
    kppm_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = kppm_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                kppm_pkg::REG_WIDTH:  n_cfg.width  = pwdata[kppm_pkg::DIM_W-1:0];
                kppm_pkg::REG_HEIGHT: n_cfg.height = pwdata[kppm_pkg::DIM_W-1:0];
                kppm_pkg::REG_MARGIN: n_cfg.margin = pwdata[kppm_pkg::MARGIN_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            kppm_pkg::REG_WIDTH:  prdata = kppm_pkg::APB_DW'(r_cfg.width);
            kppm_pkg::REG_HEIGHT: prdata = kppm_pkg::APB_DW'(r_cfg.height);
            kppm_pkg::REG_MARGIN: prdata = kppm_pkg::APB_DW'(r_cfg.margin);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= kppm_pkg::WIDTH_RESET;
            r_cfg.height <= kppm_pkg::HEIGHT_RESET;
            r_cfg.margin <= kppm_pkg::MARGIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/kppm_palette.sv @@
// Palette memory of the keyed palette pixel merge: one write port and
// two registered read ports. Entries past the depth read as black.
// Uses kppm_pkg.
`timescale 1ns / 1ps

module kppm_palette #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [kppm_pkg::PIXEL_W-1:0]  i_wr_addr,
    input  logic [kppm_pkg::COLOR_W-1:0]  i_wr_color,
    input  logic                          i_rd_en,
    input  logic [kppm_pkg::PIXEL_W-1:0]  i_rd_addr_a,
    input  logic [kppm_pkg::PIXEL_W-1:0]  i_rd_addr_b,
    output logic [kppm_pkg::COLOR_W-1:0]  o_rd_color_a,
    output logic [kppm_pkg::COLOR_W-1:0]  o_rd_color_b
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = kppm_pkg::PIXEL_W + 1;

    logic [kppm_pkg::COLOR_W-1:0] r_palette [PALETTE_DEPTH];
    logic [kppm_pkg::COLOR_W-1:0] r_rd_a;
    logic [kppm_pkg::COLOR_W-1:0] r_rd_b;
    logic                         r_oor_a;
    logic                         r_oor_b;
    logic                         wr_ok;
    logic                         oor_a;
    logic                         oor_b;

    assign wr_ok = CW'(i_wr_addr) < CW'(PALETTE_DEPTH);
    assign oor_a = CW'(i_rd_addr_a) >= CW'(PALETTE_DEPTH);
    assign oor_b = CW'(i_rd_addr_b) >= CW'(PALETTE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok) begin
            r_palette[i_wr_addr[AW-1:0]] <= i_wr_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a  <= r_palette[i_rd_addr_a[AW-1:0]];
            r_rd_b  <= r_palette[i_rd_addr_b[AW-1:0]];
            r_oor_a <= oor_a;
            r_oor_b <= oor_b;
        end
    end

    assign o_rd_color_a = r_oor_a ? '0 : r_rd_a;
    assign o_rd_color_b = r_oor_b ? '0 : r_rd_b;

endmodule

@@ hdl/kppm_position.sv @@
// Raster position tracker of the keyed palette pixel merge.
// Keeps column and row counters, flags the border window and frame end.
// Uses kppm_pkg.
`timescale 1ns / 1ps

module kppm_position #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kppm_pkg::t_cfg      i_cfg,
    input  logic                i_advance,
    output kppm_pkg::t_pos_info o_info
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DW = CW + 1;
    localparam int SW = ((DW > kppm_pkg::MARGIN_W) ? DW : kppm_pkg::MARGIN_W) + 1;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [SW-1:0] x_ext;
    logic [SW-1:0] y_ext;
    logic [SW-1:0] m_ext;
    logic [SW-1:0] w_ext;
    logic [SW-1:0] h_ext;
    logic          end_row;
    logic          end_frame;

    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = DW'(1);
        end else if (32'(i_cfg.width) > 32'(MAX_DIMENSION)) begin
            w_eff = DW'(MAX_DIMENSION);
        end else begin
            w_eff = DW'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h_eff = DW'(1);
        end else if (32'(i_cfg.height) > 32'(MAX_DIMENSION)) begin
            h_eff = DW'(MAX_DIMENSION);
        end else begin
            h_eff = DW'(i_cfg.height);
        end
    end

    assign x_ext = SW'(r_col);
    assign y_ext = SW'(r_row);
    assign m_ext = SW'(i_cfg.margin);
    assign w_ext = SW'(w_eff);
    assign h_ext = SW'(h_eff);

    assign end_row   = (x_ext + SW'(1)) >= w_ext;
    assign end_frame = end_row && ((y_ext + SW'(1)) >= h_ext);

    assign o_info.in_window = (x_ext >= m_ext) && ((x_ext + m_ext) < w_ext) &&
                              (y_ext >= m_ext) && ((y_ext + m_ext) < h_ext);
    assign o_info.end_frame = end_frame;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (end_row) begin
                n_col = '0;
                n_row = end_frame ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ hdl/kppm_merge.sv @@
// Key color match and index selection of the keyed palette pixel merge.
// Compares both palette colors against the key table; uses kppm_pkg.
`timescale 1ns / 1ps

module kppm_merge #(
    parameter int KEY_COLOR_COUNT = 24
) (
    input  logic [kppm_pkg::COLOR_W-1:0] i_base_color,
    input  logic [kppm_pkg::COLOR_W-1:0] i_over_color,
    input  logic [kppm_pkg::PIXEL_W-1:0] i_base_pixel,
    input  logic [kppm_pkg::PIXEL_W-1:0] i_over_pixel,
    input  kppm_pkg::t_pos_info          i_info,
    output logic [kppm_pkg::PIXEL_W-1:0] o_result_pixel,
    output logic                         o_replaced,
    output logic                         o_last_in_frame
);

    logic base_key;
    logic over_key;
    logic take;

    always_comb begin
        base_key = 1'b0;
        over_key = 1'b0;
        for (int i = 0; i < kppm_pkg::KEY_TABLE_SIZE; i++) begin
            if (i < KEY_COLOR_COUNT) begin
                if (kppm_pkg::KEY_COLORS[i] == i_base_color) begin
                    base_key = 1'b1;
                end
                if (kppm_pkg::KEY_COLORS[i] == i_over_color) begin
                    over_key = 1'b1;
                end
            end
        end
    end

    assign take            = i_info.in_window && base_key && !over_key;
    assign o_result_pixel  = take ? i_over_pixel : i_base_pixel;
    assign o_replaced      = take;
    assign o_last_in_frame = i_info.end_frame;

endmodule

@@ hdl/keyed_palette_pixel_merge.sv @@
// Channel   Dir  Handshake              Content
// s_axis    in   tvalid/tready          palette write or pixel pair
// m_axis    out  tvalid/tready          merged pixel, replaced flag, frame end
// apb       in   psel/penable/pready    width, height and margin registers
//
// One item is accepted per cycle while the output is not stalled; a pixel
// result passes the registered palette read and the output register.
// Palette writes produce no result. Reset clears the counters and the pipeline
// and resets the registers; palette contents are undefined until written.
// A stalled output holds its result and one more pixel waits in the read stage.
// Top level of the keyed palette pixel merge; uses kppm_pkg, kppm_cfg,
// kppm_palette, kppm_position and kppm_merge.
`timescale 1ns / 1ps

module keyed_palette_pixel_merge #(
    parameter int PALETTE_DEPTH   = 256,
    parameter int KEY_COLOR_COUNT = 24,
    parameter int MAX_DIMENSION   = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // palette_index [7:0], palette_color [31:8], base_pixel [39:32],
    // overlay_pixel [47:40]
    input  logic [47:0]                       s_axis_tdata,
    // operation [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_pixel [7:0]
    output logic [kppm_pkg::PIXEL_W-1:0]      m_axis_tdata,
    // replaced [0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kppm_pkg::APB_AW-1:0]       paddr,
    input  logic [kppm_pkg::APB_DW-1:0]       pwdata,
    output logic [kppm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    kppm_pkg::t_cfg      cfg;
    kppm_pkg::t_pos_info pos_info;
    kppm_pkg::t_pos_info r_s1_info;
    kppm_pkg::t_op       in_op;

    logic                         accept;
    logic                         acc_pixel;
    logic                         acc_write;
    logic                         out_free;
    logic                         s1_adv;
    logic                         r_s1_vld;
    logic                         n_s1_vld;
    logic [kppm_pkg::PIXEL_W-1:0] r_s1_base;
    logic [kppm_pkg::PIXEL_W-1:0] r_s1_over;
    logic [kppm_pkg::COLOR_W-1:0] base_color;
    logic [kppm_pkg::COLOR_W-1:0] over_color;
    logic [kppm_pkg::PIXEL_W-1:0] mg_pixel;
    logic                         mg_replaced;
    logic                         mg_last;
    logic                         r_out_vld;
    logic                         n_out_vld;
    logic [kppm_pkg::PIXEL_W-1:0] r_out_pixel;
    logic                         r_out_replaced;
    logic                         r_out_last;

    assign in_op     = kppm_pkg::t_op'(s_axis_tuser);
    assign out_free  = !r_out_vld || m_axis_tready;
    assign s1_adv    = r_s1_vld && out_free;
    assign s_axis_tready = i_rst_n && (!r_s1_vld || out_free);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign acc_pixel = accept && (in_op == kppm_pkg::OP_PIXEL);
    assign acc_write = accept && (in_op == kppm_pkg::OP_PALETTE_WRITE);

    kppm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kppm_position #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (acc_pixel),
        .o_info    (pos_info)
    );

    kppm_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk        (i_clk),
        .i_wr_en      (acc_write),
        .i_wr_addr    (s_axis_tdata[7:0]),
        .i_wr_color   (s_axis_tdata[31:8]),
        .i_rd_en      (acc_pixel),
        .i_rd_addr_a  (s_axis_tdata[39:32]),
        .i_rd_addr_b  (s_axis_tdata[47:40]),
        .o_rd_color_a (base_color),
        .o_rd_color_b (over_color)
    );

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (acc_pixel) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
        n_out_vld = out_free ? r_s1_vld : r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_pixel) begin
            r_s1_base <= s_axis_tdata[39:32];
            r_s1_over <= s_axis_tdata[47:40];
            r_s1_info <= pos_info;
        end
    end

    kppm_merge #(
        .KEY_COLOR_COUNT (KEY_COLOR_COUNT)
    ) u_merge (
        .i_base_color    (base_color),
        .i_over_color    (over_color),
        .i_base_pixel    (r_s1_base),
        .i_over_pixel    (r_s1_over),
        .i_info          (r_s1_info),
        .o_result_pixel  (mg_pixel),
        .o_replaced      (mg_replaced),
        .o_last_in_frame (mg_last)
    );

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pixel    <= mg_pixel;
            r_out_replaced <= mg_replaced;
            r_out_last     <= mg_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_pixel;
    assign m_axis_tuser  = r_out_replaced;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ hdl/kppm_checker.sv @@
// Port-level checker of the keyed palette pixel merge and its bind.
// Depends on keyed_palette_pixel_merge_macros.svh and the top level ports.
`timescale 1ns / 1ps
`include "keyed_palette_pixel_merge_macros.svh"

module kppm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic pixel_xfer;

    assign pixel_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser;

    // A stalled result stays put until its transfer.
    `KPPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // Every accepted pixel is followed by a valid result after the read stage and the output register.
    `KPPM_ASSERT_NOW(a_pixel_result, pixel_xfer, ##2 m_axis_tvalid, "accepted pixel produced no result")

    // A new result only follows a pixel accepted through the read stage and the output register.
    `KPPM_ASSERT_NOW(a_no_phantom, $rose(m_axis_tvalid), $past(pixel_xfer, 2), "result without an accepted pixel")

    // With the output register empty the input side is never held off.
    `KPPM_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind keyed_palette_pixel_merge kppm_checker u_kppm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
